>>> rtl/incremental_pid_speed_controller_defines.svh
// ---------------------------------------------------------------------------
// Incremental PID speed controller assertion macros
// Shared property shorthands, all sampled on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_SPEED_CONTROLLER_DEFINES_SVH
`define INCREMENTAL_PID_SPEED_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipsc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipsc assertion failed");

`endif

>>> rtl/ipsc_pkg.sv
// ---------------------------------------------------------------------------
// ipsc_pkg
// Widths, register indexes and reset values of the PID speed controller.
// ---------------------------------------------------------------------------
package ipsc_pkg;

    localparam int MEAS_W    = 16;
    localparam int ERR_W     = 17;
    localparam int SUM_W     = 21;
    localparam int GAIN_W    = 20;
    localparam int DUTY_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int ACC_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 20;

    // First and second error differences.
    localparam int DIFF1_W = ERR_W + 1;
    localparam int DIFF2_W = ERR_W + 2;
    // Gains carry a zero sign bit into the signed multipliers.
    localparam int GAIN_S_W = GAIN_W + 1;
    localparam int PROD_P_W = DIFF1_W + GAIN_S_W;
    localparam int PROD_I_W = ERR_W + GAIN_S_W;
    localparam int PROD_D_W = DIFF2_W + GAIN_S_W;
    // Accumulator plus the three products, with headroom.
    localparam int WIDE_W  = PROD_D_W + 3;
    localparam int ISUM_W  = SUM_W + 1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_TARGET_SPEED      = 3'd0;
    localparam cfg_idx_t REG_GAIN_PROPORTIONAL = 3'd1;
    localparam cfg_idx_t REG_GAIN_INTEGRAL     = 3'd2;
    localparam cfg_idx_t REG_GAIN_DERIVATIVE   = 3'd3;
    localparam cfg_idx_t REG_INTEGRAL_BOUND    = 3'd4;
    localparam cfg_idx_t REG_DUTY_UPPER        = 3'd5;
    localparam cfg_idx_t REG_DUTY_LOWER        = 3'd6;

    localparam logic signed [MEAS_W-1:0] RST_TARGET_SPEED = 16'sd0;
    localparam logic [GAIN_W-1:0]        RST_GAIN_P       = 20'd1311;
    localparam logic [GAIN_W-1:0]        RST_GAIN_I       = 20'd3277;
    localparam logic [GAIN_W-1:0]        RST_GAIN_D       = 20'd6554;
    localparam logic [GAIN_W-1:0]        RST_INT_BOUND    = 20'd4000;
    localparam logic signed [DUTY_W-1:0] RST_DUTY_UPPER   = 16'sd10000;
    localparam logic signed [DUTY_W-1:0] RST_DUTY_LOWER   = -16'sd10000;

endpackage

>>> rtl/incremental_pid_speed_controller.sv
// ---------------------------------------------------------------------------
// incremental_pid_speed_controller
// Incremental PID on a measured speed, Q16.16 duty accumulator, integer duty.
// ---------------------------------------------------------------------------
// Each measurement word is taken into an input register and produces one
// result word in the result register; a new measurement is accepted every
// cycle as long as the result register is free or being taken. The duty
// accumulator, the two previous errors and the error integral are updated
// together, with three multiplies of a 21-bit signed gain by an error term
// of 17 to 19 bits, their sum and the clamps. Configuration writes take effect
// at once and must be made while no word is in flight.
`include "incremental_pid_speed_controller_defines.svh"

module incremental_pid_speed_controller
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ipsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ipsc_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ipsc_pkg::MEAS_W-1:0]    measurement,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ipsc_pkg::DUTY_W-1:0]    duty,
    output logic signed [ipsc_pkg::ERR_W-1:0]     error_now,
    output logic signed [ipsc_pkg::SUM_W-1:0]     error_sum
);

    // Configuration registers.
    logic signed [ipsc_pkg::MEAS_W-1:0] target_reg;
    logic [ipsc_pkg::GAIN_W-1:0]        kp_reg;
    logic [ipsc_pkg::GAIN_W-1:0]        ki_reg;
    logic [ipsc_pkg::GAIN_W-1:0]        kd_reg;
    logic [ipsc_pkg::GAIN_W-1:0]        bound_reg;
    logic signed [ipsc_pkg::DUTY_W-1:0] upper_reg;
    logic signed [ipsc_pkg::DUTY_W-1:0] lower_reg;

    // Controller state.
    logic signed [ipsc_pkg::ACC_W-1:0]  acc_reg;
    logic signed [ipsc_pkg::ACC_W-1:0]  acc_next;
    logic signed [ipsc_pkg::ERR_W-1:0]  err_prev_reg;
    logic signed [ipsc_pkg::ERR_W-1:0]  err_prev2_reg;
    logic signed [ipsc_pkg::SUM_W-1:0]  integral_reg;
    logic signed [ipsc_pkg::SUM_W-1:0]  integral_next;

    // Input and result registers.
    logic                               in_full_reg;
    logic signed [ipsc_pkg::MEAS_W-1:0] meas_reg;
    logic                               out_valid_reg;
    logic signed [ipsc_pkg::DUTY_W-1:0] duty_reg;
    logic signed [ipsc_pkg::DUTY_W-1:0] duty_next;
    logic signed [ipsc_pkg::ERR_W-1:0]  err_out_reg;
    logic signed [ipsc_pkg::SUM_W-1:0]  sum_out_reg;

    logic in_accept;
    logic advance;

    logic signed [ipsc_pkg::ERR_W-1:0]    err;
    logic signed [ipsc_pkg::DIFF1_W-1:0]  diff1;
    logic signed [ipsc_pkg::DIFF2_W-1:0]  diff2;
    logic signed [ipsc_pkg::GAIN_S_W-1:0] kp_s;
    logic signed [ipsc_pkg::GAIN_S_W-1:0] ki_s;
    logic signed [ipsc_pkg::GAIN_S_W-1:0] kd_s;
    logic signed [ipsc_pkg::PROD_P_W-1:0] prod_p;
    logic signed [ipsc_pkg::PROD_I_W-1:0] prod_i;
    logic signed [ipsc_pkg::PROD_D_W-1:0] prod_d;
    logic signed [ipsc_pkg::WIDE_W-1:0]   acc_sum;
    logic signed [ipsc_pkg::WIDE_W-1:0]   hi_wide;
    logic signed [ipsc_pkg::WIDE_W-1:0]   lo_wide;
    logic signed [ipsc_pkg::ACC_W-1:0]    hi_q;
    logic signed [ipsc_pkg::ACC_W-1:0]    lo_q;
    logic                                 frozen;
    logic signed [ipsc_pkg::ISUM_W-1:0]   isum;
    logic signed [ipsc_pkg::ISUM_W-1:0]   bound_pos;
    logic signed [ipsc_pkg::ISUM_W-1:0]   bound_neg;

    // ------------------------------------------------------------------
    // Handshake: the input register moves on whenever the result register
    // is empty or its word is taken in the same cycle.
    // ------------------------------------------------------------------
    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;
    assign error_now = err_out_reg;
    assign error_sum = sum_out_reg;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign hi_q = {upper_reg, {ipsc_pkg::FRAC_W{1'b0}}};
    assign lo_q = {lower_reg, {ipsc_pkg::FRAC_W{1'b0}}};

    assign kp_s = $signed({1'b0, kp_reg});
    assign ki_s = $signed({1'b0, ki_reg});
    assign kd_s = $signed({1'b0, kd_reg});

    always_comb
    begin
        err   = ipsc_pkg::ERR_W'(target_reg) - ipsc_pkg::ERR_W'(meas_reg);
        diff1 = ipsc_pkg::DIFF1_W'(err) - ipsc_pkg::DIFF1_W'(err_prev_reg);
        diff2 = ipsc_pkg::DIFF2_W'(err)
              - (ipsc_pkg::DIFF2_W'(err_prev_reg) <<< 1)
              + ipsc_pkg::DIFF2_W'(err_prev2_reg);

        prod_p = diff1 * kp_s;
        prod_i = err * ki_s;
        prod_d = diff2 * kd_s;

        acc_sum = ipsc_pkg::WIDE_W'(acc_reg)
                + ipsc_pkg::WIDE_W'(prod_p)
                + ipsc_pkg::WIDE_W'(prod_i)
                + ipsc_pkg::WIDE_W'(prod_d);

        hi_wide = ipsc_pkg::WIDE_W'(hi_q);
        lo_wide = ipsc_pkg::WIDE_W'(lo_q);

        // With crossed limits a sum below the lower one gives the lower, any other the upper.
        priority if (acc_sum < lo_wide)
            acc_next = lo_q;
        else if (acc_sum > hi_wide)
            acc_next = hi_q;
        else
            acc_next = ipsc_pkg::ACC_W'(acc_sum);

        // Truncate toward zero: a negative value with a fraction rounds up.
        duty_next = acc_next[ipsc_pkg::ACC_W-1 -: ipsc_pkg::DUTY_W]
                  + ipsc_pkg::DUTY_W'(acc_next[ipsc_pkg::ACC_W-1]
                                      && (|acc_next[ipsc_pkg::FRAC_W-1:0]));

        // The freeze test looks at the accumulator before this update.
        frozen = ((acc_reg >= hi_q) && (err > 0)) || ((acc_reg <= lo_q) && (err < 0));

        isum      = ipsc_pkg::ISUM_W'(integral_reg) + ipsc_pkg::ISUM_W'(err);
        bound_pos = $signed({2'b00, bound_reg});
        bound_neg = -bound_pos;

        priority if (frozen)
            integral_next = integral_reg;
        else if (isum < bound_neg)
            integral_next = ipsc_pkg::SUM_W'(bound_neg);
        else if (isum > bound_pos)
            integral_next = ipsc_pkg::SUM_W'(bound_pos);
        else
            integral_next = ipsc_pkg::SUM_W'(isum);
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= ipsc_pkg::RST_TARGET_SPEED;
            kp_reg     <= ipsc_pkg::RST_GAIN_P;
            ki_reg     <= ipsc_pkg::RST_GAIN_I;
            kd_reg     <= ipsc_pkg::RST_GAIN_D;
            bound_reg  <= ipsc_pkg::RST_INT_BOUND;
            upper_reg  <= ipsc_pkg::RST_DUTY_UPPER;
            lower_reg  <= ipsc_pkg::RST_DUTY_LOWER;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ipsc_pkg::REG_TARGET_SPEED:
                    target_reg <= $signed(cfg_data[ipsc_pkg::MEAS_W-1:0]);
                ipsc_pkg::REG_GAIN_PROPORTIONAL:
                    kp_reg <= cfg_data[ipsc_pkg::GAIN_W-1:0];
                ipsc_pkg::REG_GAIN_INTEGRAL:
                    ki_reg <= cfg_data[ipsc_pkg::GAIN_W-1:0];
                ipsc_pkg::REG_GAIN_DERIVATIVE:
                    kd_reg <= cfg_data[ipsc_pkg::GAIN_W-1:0];
                ipsc_pkg::REG_INTEGRAL_BOUND:
                    bound_reg <= cfg_data[ipsc_pkg::GAIN_W-1:0];
                ipsc_pkg::REG_DUTY_UPPER:
                    upper_reg <= $signed(cfg_data[ipsc_pkg::DUTY_W-1:0]);
                ipsc_pkg::REG_DUTY_LOWER:
                    lower_reg <= $signed(cfg_data[ipsc_pkg::DUTY_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            err_prev_reg  <= '0;
            err_prev2_reg <= '0;
            integral_reg  <= '0;
        end
        else
        begin
            in_full_reg   <= in_accept || (in_full_reg && !advance);
            out_valid_reg <= advance || (out_valid_reg && out_stall);
            if (advance)
            begin
                acc_reg       <= acc_next;
                err_prev_reg  <= err;
                err_prev2_reg <= err_prev_reg;
                integral_reg  <= integral_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            meas_reg <= measurement;
        end
        if (advance)
        begin
            duty_reg    <= duty_next;
            err_out_reg <= err;
            sum_out_reg <= integral_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IPSC_ASSERT_NEXT(a_duty_in_limits, advance && (lower_reg <= upper_reg),
        (duty_reg <= $past(upper_reg)) && (duty_reg >= $past(lower_reg)))
    `IPSC_ASSERT_NEXT(a_integral_frozen, advance && frozen, $stable(integral_reg))
    `IPSC_ASSERT_NEXT(a_integral_bounded, advance && !frozen,
        (ipsc_pkg::ISUM_W'(integral_reg) <= $past(bound_pos))
        && (ipsc_pkg::ISUM_W'(integral_reg) >= $past(bound_neg)))
    `IPSC_ASSERT_NEXT(a_error_history, advance,
        (err_prev2_reg == $past(err_prev_reg)) && (err_prev_reg == err_out_reg))
    `IPSC_ASSERT_SAME(a_stall_only_when_full, in_stall, in_full_reg && out_valid_reg)

endmodule
